// ----- hw/rtl/svmt_pkg.sv -----
// Shared types, codes and helper functions of the linear SVM trainer.
package svmt_pkg;

   localparam int DEF_MAX_FEATURES = 4096;
   localparam int DEF_MAX_CLASSES  = 16;
   localparam int CMD_QUEUE_DEPTH  = 2;
   localparam int CSR_ADDR_W       = 4;

   localparam logic [1:0] OPC_CLEAR   = 2'd0;
   localparam logic [1:0] OPC_TRAIN   = 2'd1;
   localparam logic [1:0] OPC_PREDICT = 2'd2;
   localparam logic [1:0] OPC_IGNORE  = 2'd3;

   localparam logic [1:0] CSR_LEARN_RATE    = 2'd0;
   localparam logic [1:0] CSR_REG_LAMBDA    = 2'd1;
   localparam logic [1:0] CSR_CLASS_COUNT   = 2'd2;
   localparam logic [1:0] CSR_FEATURE_COUNT = 2'd3;

   localparam logic [31:0] RST_LEARN_RATE    = 32'd42950;
   localparam logic [19:0] RST_REG_LAMBDA    = 20'd6554;
   localparam logic [4:0]  RST_CLASS_COUNT   = 5'd10;
   localparam logic [12:0] RST_FEATURE_COUNT = 13'd3073;

   typedef enum logic [1:0] {
      KIND_CLEAR   = 2'd0,
      KIND_TRAIN   = 2'd1,
      KIND_PREDICT = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type   kind;
      logic [3:0] label;
   } cmd_type;

   typedef struct packed {
      logic idle;
      logic wiped;
   } back_status_type;

   typedef struct packed {
      logic [31:0] learn_rate;
      logic [19:0] reg_lambda;
      logic [4:0]  class_count;
      logic [12:0] feature_count;
   } cfg_type;

   function automatic logic [31:0] clamp_count(input logic [31:0] value,
                                                input logic [31:0] limit);
      logic [31:0] r;
      if (value == 32'd0) begin
         r = 32'd1;
      end else if (value > limit) begin
         r = limit;
      end else begin
         r = value;
      end
      return r;
   endfunction

endpackage

// ----- hw/rtl/svmt_ifs.sv -----
// Valid/ready channel interfaces for sample elements and results.
interface svmt_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  opcode;
   logic [15:0] feature_value;
   logic [3:0]  sample_label;

   modport source (output valid, output opcode, output feature_value, output sample_label,
                   input ready);
   modport sink (input valid, input opcode, input feature_value, input sample_label,
                 output ready);
endinterface

interface svmt_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         result_kind;
   logic [3:0]         predicted_class;
   logic signed [47:0] best_score;
   logic [4:0]         margin_misses;

   modport source (output valid, output result_kind, output predicted_class,
                   output best_score, output margin_misses, input ready);
   modport sink (input valid, input result_kind, input predicted_class,
                 input best_score, input margin_misses, output ready);
endinterface

// ----- hw/rtl/linear_svm_sgd_trainer.sv -----
// Top level of the one-vs-rest linear SVM trainer with its configuration registers.
//
// Elements of a sample are taken one per cycle while the engine is idle and the command queue
// is empty. The element that completes a sample starts the engine, which works on one command
// at a time and shares one multiplier sequence and one weight memory: for each class a dot pass
// reads, multiplies and accumulates every feature, and for a training sample an update pass
// then reads, regularises, scales and writes back every weight of that class; after that the
// result is posted. A clear sweeps the whole weight memory, one word a cycle; the memory holds
// MAX_CLASSES rounded up to a power of two times MAX_FEATURES rounded up to a power of two
// words (65536 with the defaults). The same sweep runs after reset, and no element is
// accepted until it ends. Clear commands queue behind a running job in a two-entry queue.
module linear_svm_sgd_trainer
   import svmt_pkg::*;
#(
   parameter int MAX_FEATURES = DEF_MAX_FEATURES,
   parameter int MAX_CLASSES  = DEF_MAX_CLASSES
) (
   input  logic                  clock,
   input  logic                  reset,
   svmt_req_if.sink              req_ch,
   svmt_rsp_if.source            rsp_ch,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   localparam int FA_W = $clog2(MAX_FEATURES);

   cfg_type         cfg_ff;
   cfg_type         cfg_in;
   back_status_type status;
   logic            push;
   logic            pop;
   cmd_type         push_cmd;
   cmd_type         pop_cmd;
   logic            q_full;
   logic            q_empty;
   logic            buf_we;
   logic [FA_W-1:0] buf_waddr;
   logic [15:0]     buf_wdata;
   logic            csr_write;
   logic [1:0]      csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = csr_paddr[3:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_LEARN_RATE:    cfg_in.learn_rate    = csr_pwdata;
            CSR_REG_LAMBDA:    cfg_in.reg_lambda    = csr_pwdata[19:0];
            CSR_CLASS_COUNT:   cfg_in.class_count   = csr_pwdata[4:0];
            CSR_FEATURE_COUNT: cfg_in.feature_count = csr_pwdata[12:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         CSR_LEARN_RATE:    csr_prdata = cfg_ff.learn_rate;
         CSR_REG_LAMBDA:    csr_prdata = 32'(cfg_ff.reg_lambda);
         CSR_CLASS_COUNT:   csr_prdata = 32'(cfg_ff.class_count);
         CSR_FEATURE_COUNT: csr_prdata = 32'(cfg_ff.feature_count);
         default:           csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.learn_rate    <= RST_LEARN_RATE;
         cfg_ff.reg_lambda    <= RST_REG_LAMBDA;
         cfg_ff.class_count   <= RST_CLASS_COUNT;
         cfg_ff.feature_count <= RST_FEATURE_COUNT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   svmt_front #(
      .MAX_FEATURES(MAX_FEATURES)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .cfg       (cfg_ff),
      .status    (status),
      .q_full    (q_full),
      .q_empty   (q_empty),
      .push      (push),
      .push_cmd  (push_cmd),
      .buf_we    (buf_we),
      .buf_waddr (buf_waddr),
      .buf_wdata (buf_wdata)
   );

   svmt_cmd_fifo #(
      .DEPTH(CMD_QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .pop_cmd  (pop_cmd),
      .full     (q_full),
      .empty    (q_empty)
   );

   svmt_back #(
      .MAX_FEATURES(MAX_FEATURES),
      .MAX_CLASSES (MAX_CLASSES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_empty   (q_empty),
      .pop_cmd   (pop_cmd),
      .pop       (pop),
      .status    (status),
      .buf_we    (buf_we),
      .buf_waddr (buf_waddr),
      .buf_wdata (buf_wdata),
      .rsp       (rsp_ch)
   );

endmodule

// ----- hw/rtl/svmt_front.sv -----
// Front end: accepts elements, fills the sample buffer and issues commands.
module svmt_front
   import svmt_pkg::*;
#(
   parameter int MAX_FEATURES = DEF_MAX_FEATURES
) (
   input  logic                                clock,
   input  logic                                reset,
   svmt_req_if.sink                            req,
   input  cfg_type                             cfg,
   input  back_status_type                     status,
   input  logic                                q_full,
   input  logic                                q_empty,
   output logic                                push,
   output cmd_type                             push_cmd,
   output logic                                buf_we,
   output logic [$clog2(MAX_FEATURES)-1:0]     buf_waddr,
   output logic [15:0]                         buf_wdata
);

   localparam int FA_W = $clog2(MAX_FEATURES);
   localparam int FC_W = $clog2(MAX_FEATURES + 1);

   logic [FC_W-1:0] count_ff;
   logic [FC_W-1:0] count_in;
   logic [FC_W-1:0] n_feat;
   logic            is_elem;
   logic            last;
   logic            take;

   assign n_feat  = FC_W'(clamp_count(32'(cfg.feature_count), 32'(MAX_FEATURES)));
   assign is_elem = (req.opcode == OPC_TRAIN) || (req.opcode == OPC_PREDICT);
   assign last    = ((FC_W + 1)'(count_ff) + (FC_W + 1)'(1)) >= (FC_W + 1)'(n_feat);

   assign req.ready = status.wiped && !q_full && (!is_elem || (q_empty && status.idle));
   assign take      = req.valid && req.ready;

   assign push           = take && ((req.opcode == OPC_CLEAR) || (is_elem && last));
   assign push_cmd.label = req.sample_label;
   always_comb begin
      unique case (req.opcode)
         OPC_CLEAR: push_cmd.kind = KIND_CLEAR;
         OPC_TRAIN: push_cmd.kind = KIND_TRAIN;
         default:   push_cmd.kind = KIND_PREDICT;
      endcase
   end

   assign buf_we    = take && is_elem;
   assign buf_waddr = count_ff[FA_W-1:0];
   assign buf_wdata = req.feature_value;

   always_comb begin
      count_in = count_ff;
      if (take && (req.opcode == OPC_CLEAR)) begin
         count_in = '0;
      end else if (take && is_elem) begin
         count_in = last ? '0 : count_ff + FC_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   a_clear_drops_partial: assert property (@(posedge clock) disable iff (reset)
      (take && (req.opcode == OPC_CLEAR)) |=> (count_ff == '0))
      else $error("Element count not cleared by a clear transaction.");

   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      (count_ff < FC_W'(MAX_FEATURES)))
      else $error("Element count left the buffer range.");

endmodule

// ----- hw/rtl/svmt_cmd_fifo.sv -----
// Short command queue between the front end and the compute engine.
module svmt_cmd_fifo
   import svmt_pkg::*;
#(
   parameter int DEPTH = CMD_QUEUE_DEPTH
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   input  logic    pop,
   output cmd_type pop_cmd,
   output logic    full,
   output logic    empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   cmd_type         slots_ff [DEPTH];
   logic [PW-1:0]   wr_ff;
   logic [PW-1:0]   rd_ff;
   logic [CW-1:0]   cnt_ff;
   logic [PW-1:0]   wr_in;
   logic [PW-1:0]   rd_in;
   logic [CW-1:0]   cnt_in;

   assign full    = (cnt_ff == CW'(DEPTH));
   assign empty   = (cnt_ff == '0);
   assign pop_cmd = slots_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == PW'(DEPTH - 1)) ? '0 : wr_ff + PW'(1);
      end
      if (pop) begin
         rd_in = (rd_ff == PW'(DEPTH - 1)) ? '0 : rd_ff + PW'(1);
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + CW'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

// ----- hw/rtl/svmt_back.sv -----
// Compute engine: weight memory, dot products, SGD updates, argmax and result register.
module svmt_back
   import svmt_pkg::*;
#(
   parameter int MAX_FEATURES = DEF_MAX_FEATURES,
   parameter int MAX_CLASSES  = DEF_MAX_CLASSES
) (
   input  logic                            clock,
   input  logic                            reset,
   input  cfg_type                         cfg,
   input  logic                            q_empty,
   input  cmd_type                         pop_cmd,
   output logic                            pop,
   output back_status_type                 status,
   input  logic                            buf_we,
   input  logic [$clog2(MAX_FEATURES)-1:0] buf_waddr,
   input  logic [15:0]                     buf_wdata,
   svmt_rsp_if.source                      rsp
);

   localparam int FA_W  = $clog2(MAX_FEATURES);
   localparam int FC_W  = $clog2(MAX_FEATURES + 1);
   localparam int CA_W  = $clog2(MAX_CLASSES);
   localparam int CC_W  = $clog2(MAX_CLASSES + 1);
   localparam int WA_W  = FA_W + CA_W;
   localparam int WORDS = 1 << WA_W;
   localparam int ACC_W = 57 + FA_W;

   localparam logic signed [ACC_W-1:0] MARGIN_POS = ACC_W'(64'sd1 <<< 39);
   localparam logic signed [ACC_W-1:0] MARGIN_NEG = -MARGIN_POS;
   localparam logic signed [87:0]      ROUND_HALF = 88'sd1 <<< 47;

   typedef enum logic [12:0] {
      ST_IDLE  = 13'b0000000000001,
      ST_WIPE  = 13'b0000000000010,
      ST_DRD   = 13'b0000000000100,
      ST_DMUL  = 13'b0000000001000,
      ST_DACC  = 13'b0000000010000,
      ST_DEND  = 13'b0000000100000,
      ST_URD   = 13'b0000001000000,
      ST_ULAM  = 13'b0000010000000,
      ST_UGRAD = 13'b0000100000000,
      ST_ULO   = 13'b0001000000000,
      ST_UHI   = 13'b0010000000000,
      ST_UWR   = 13'b0100000000000,
      ST_DONE  = 13'b1000000000000
   } state_type;

   logic signed [31:0] wmem [WORDS];
   logic [15:0]        xmem [MAX_FEATURES];

   state_type                 state_ff;
   state_type                 state_in;
   kind_type                  kind_ff;
   logic [3:0]                label_ff;
   logic [CC_W-1:0]           c_ff;
   logic [FC_W-1:0]           j_ff;
   logic [WA_W-1:0]           wipe_ff;
   logic                      init_ff;
   logic signed [ACC_W-1:0]   acc_ff;
   logic signed [48:0]        prod_ff;
   logic signed [ACC_W-1:0]   best_ff;
   logic [CA_W-1:0]           best_c_ff;
   logic                      miss_ff;
   logic [CC_W-1:0]           misses_ff;
   logic signed [31:0]        w_rd_ff;
   logic [15:0]               x_rd_ff;
   logic signed [31:0]        w_ff;
   logic [15:0]               x_ff;
   logic signed [52:0]        lw_ff;
   logic signed [53:0]        g_ff;
   logic [58:0]               plo_ff;
   logic signed [59:0]        phi_ff;
   logic                      rsp_valid_ff;
   logic [1:0]                rsp_kind_ff;
   logic [3:0]                rsp_class_ff;
   logic signed [47:0]        rsp_score_ff;
   logic [4:0]                rsp_misses_ff;

   logic [FC_W-1:0]           n_feat;
   logic [CC_W-1:0]           n_cls;
   logic                      last_feat;
   logic                      last_cls;
   logic [WA_W-1:0]           w_addr;
   logic                      w_we;
   logic [WA_W-1:0]           w_waddr;
   logic signed [31:0]        w_wdata;
   logic                      pos;
   logic                      miss;
   logic signed [53:0]        g_next;
   logic signed [87:0]        step_sum;
   logic signed [39:0]        delta;
   logic signed [40:0]        w_new;
   logic signed [31:0]        w_sat;
   logic signed [ACC_W-1:0]   score_shr;
   logic signed [47:0]        score_sat;
   logic                      rsp_load;

   assign n_feat    = FC_W'(clamp_count(32'(cfg.feature_count), 32'(MAX_FEATURES)));
   assign n_cls     = CC_W'(clamp_count(32'(cfg.class_count), 32'(MAX_CLASSES)));
   assign last_feat = ((FC_W + 1)'(j_ff) + (FC_W + 1)'(1)) >= (FC_W + 1)'(n_feat);
   assign last_cls  = ((CC_W + 1)'(c_ff) + (CC_W + 1)'(1)) >= (CC_W + 1)'(n_cls);
   assign w_addr    = {c_ff[CA_W-1:0], j_ff[FA_W-1:0]};

   assign pop          = (state_ff == ST_IDLE) && !q_empty;
   assign status.idle  = (state_ff == ST_IDLE);
   assign status.wiped = !init_ff;

   assign pos  = (32'(c_ff) == 32'(label_ff));
   assign miss = pos ? (acc_ff < MARGIN_POS) : (acc_ff > MARGIN_NEG);

   always_comb begin
      g_next = $signed({lw_ff, 1'b0});
      if (miss_ff) begin
         if (pos) begin
            g_next = g_next - $signed({13'b0, x_ff, 25'b0});
         end else begin
            g_next = g_next + $signed({13'b0, x_ff, 25'b0});
         end
      end
   end

   assign step_sum = ($signed(88'(phi_ff)) <<< 27) + $signed({29'b0, plo_ff}) + ROUND_HALF;
   assign delta    = step_sum[87:48];
   assign w_new    = 41'(w_ff) - 41'(delta);
   always_comb begin
      if ((&w_new[40:31]) || !(|w_new[40:31])) begin
         w_sat = w_new[31:0];
      end else if (w_new[40]) begin
         w_sat = $signed(32'h8000_0000);
      end else begin
         w_sat = $signed(32'h7fff_ffff);
      end
   end

   assign score_shr = best_ff >>> 8;
   always_comb begin
      if (!score_shr[ACC_W-1] && (|score_shr[ACC_W-2:47])) begin
         score_sat = $signed({1'b0, {47{1'b1}}});
      end else if (score_shr[ACC_W-1] && !(&score_shr[ACC_W-2:47])) begin
         score_sat = $signed({1'b1, {47{1'b0}}});
      end else begin
         score_sat = score_shr[47:0];
      end
   end

   always_comb begin
      w_we    = 1'b0;
      w_waddr = w_addr;
      w_wdata = w_sat;
      if (state_ff == ST_WIPE) begin
         w_we    = 1'b1;
         w_waddr = wipe_ff;
         w_wdata = '0;
      end else if (state_ff == ST_UWR) begin
         w_we = 1'b1;
      end
   end

   assign rsp_load = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp.ready);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               state_in = (pop_cmd.kind == KIND_CLEAR) ? ST_WIPE : ST_DRD;
            end
         end
         ST_WIPE: begin
            if (&wipe_ff) begin
               state_in = init_ff ? ST_IDLE : ST_DONE;
            end
         end
         ST_DRD:  state_in = ST_DMUL;
         ST_DMUL: state_in = ST_DACC;
         ST_DACC: state_in = last_feat ? ST_DEND : ST_DRD;
         ST_DEND: begin
            if (kind_ff == KIND_TRAIN) begin
               state_in = ST_URD;
            end else begin
               state_in = last_cls ? ST_DONE : ST_DRD;
            end
         end
         ST_URD:   state_in = ST_ULAM;
         ST_ULAM:  state_in = ST_UGRAD;
         ST_UGRAD: state_in = ST_ULO;
         ST_ULO:   state_in = ST_UHI;
         ST_UHI:   state_in = ST_UWR;
         ST_UWR: begin
            if (!last_feat) begin
               state_in = ST_URD;
            end else begin
               state_in = last_cls ? ST_DONE : ST_DRD;
            end
         end
         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (buf_we) begin
         xmem[buf_waddr] <= buf_wdata;
      end
      x_rd_ff <= xmem[j_ff[FA_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (w_we) begin
         wmem[w_waddr] <= w_wdata;
      end
      w_rd_ff <= wmem[w_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_WIPE;
         init_ff      <= 1'b1;
         wipe_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         c_ff         <= '0;
         j_ff         <= '0;
      end else begin
         state_ff <= state_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               wipe_ff <= '0;
               c_ff    <= '0;
               j_ff    <= '0;
            end
            ST_WIPE: begin
               wipe_ff <= wipe_ff + WA_W'(1);
               if (&wipe_ff) begin
                  init_ff <= 1'b0;
               end
            end
            ST_DACC: begin
               j_ff <= last_feat ? '0 : j_ff + FC_W'(1);
            end
            ST_DEND: begin
               if ((kind_ff != KIND_TRAIN) && !last_cls) begin
                  c_ff <= c_ff + CC_W'(1);
               end
            end
            ST_UWR: begin
               j_ff <= last_feat ? '0 : j_ff + FC_W'(1);
               if (last_feat && !last_cls) begin
                  c_ff <= c_ff + CC_W'(1);
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            kind_ff   <= pop_cmd.kind;
            label_ff  <= pop_cmd.label;
            acc_ff    <= '0;
            misses_ff <= '0;
         end
         ST_DMUL: prod_ff <= w_rd_ff * $signed({1'b0, x_rd_ff});
         ST_DACC: acc_ff <= acc_ff + ACC_W'(prod_ff);
         ST_DEND: begin
            if (kind_ff == KIND_TRAIN) begin
               miss_ff   <= miss;
               misses_ff <= misses_ff + CC_W'(miss);
            end else begin
               if ((c_ff == '0) || (acc_ff > best_ff)) begin
                  best_ff   <= acc_ff;
                  best_c_ff <= c_ff[CA_W-1:0];
               end
               acc_ff <= '0;
            end
         end
         ST_ULAM: begin
            w_ff  <= w_rd_ff;
            x_ff  <= x_rd_ff;
            lw_ff <= $signed({1'b0, cfg.reg_lambda}) * w_rd_ff;
         end
         ST_UGRAD: g_ff <= g_next;
         ST_ULO:   plo_ff <= cfg.learn_rate * g_ff[26:0];
         ST_UHI:   phi_ff <= $signed({1'b0, cfg.learn_rate}) * $signed(g_ff[53:27]);
         ST_UWR: begin
            if (last_feat) begin
               acc_ff <= '0;
            end
         end
         default: begin
         end
      endcase
      if (rsp_load) begin
         rsp_kind_ff   <= kind_ff;
         rsp_class_ff  <= (kind_ff == KIND_PREDICT) ? 4'(best_c_ff) : 4'd0;
         rsp_score_ff  <= (kind_ff == KIND_PREDICT) ? score_sat : 48'sd0;
         rsp_misses_ff <= (kind_ff == KIND_TRAIN) ? 5'(misses_ff) : 5'd0;
      end
   end

   assign rsp.valid           = rsp_valid_ff;
   assign rsp.result_kind     = rsp_kind_ff;
   assign rsp.predicted_class = rsp_class_ff;
   assign rsp.best_score      = rsp_score_ff;
   assign rsp.margin_misses   = rsp_misses_ff;

   a_wipe_during_init: assert property (@(posedge clock) disable iff (reset)
      init_ff |-> (state_ff == ST_WIPE))
      else $error("Engine left the clearing pass before it finished.");

   a_buffer_quiet: assert property (@(posedge clock) disable iff (reset)
      buf_we |-> (state_ff == ST_IDLE))
      else $error("Sample buffer written while the engine reads it.");

   a_misses_bounded: assert property (@(posedge clock) disable iff (reset)
      (misses_ff <= CC_W'(MAX_CLASSES)))
      else $error("Margin miss count exceeds the class count.");

endmodule

// ----- test/svmt_checker.sv -----
// Checker for the SVM trainer: predicts results from observed traffic and compares them.
`timescale 1ns / 1ps
module svmt_checker
   import svmt_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   svmt_req_if                   req,
   svmt_rsp_if                   rsp,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   input  logic                  csr_pready,
   output int                    fail_count,
   output int                    pending
);

   typedef struct {
      kind_type           kind;
      logic [3:0]         cls;
      logic signed [47:0] score;
      logic [4:0]         misses;
   } svm_result_t;

   svm_result_t result_q[$];

   logic [31:0] eta;
   logic [19:0] lambda_q;
   logic [4:0]  classes_reg;
   logic [12:0] features_reg;

   int          weights[DEF_MAX_CLASSES*DEF_MAX_FEATURES];
   logic [15:0] sample_mem[DEF_MAX_FEATURES];
   int          element_num;
   logic [3:0]  held_label;

   function automatic int used_classes();
      int r;
      r = classes_reg;
      if (r == 0) r = 1;
      if (r > DEF_MAX_CLASSES) r = DEF_MAX_CLASSES;
      return r;
   endfunction

   function automatic int used_features();
      int r;
      r = features_reg;
      if (r == 0) r = 1;
      if (r > DEF_MAX_FEATURES) r = DEF_MAX_FEATURES;
      return r;
   endfunction

   function automatic longint class_score(int c, int n);
      longint acc;
      acc = 0;
      for (int j = 0; j < n; j++) begin
         acc += longint'(weights[c*DEF_MAX_FEATURES+j]) * longint'(sample_mem[j]);
      end
      return acc;
   endfunction

   function automatic int stepped_weight(int w, logic [15:0] x, bit miss, bit pos);
      longint g, xs, gh, gl, a, d, r;
      g = 2 * longint'(lambda_q) * longint'(w);
      if (miss) begin
         xs = longint'(x) <<< 25;
         g = pos ? g - xs : g + xs;
      end
      gh = g >>> 24;
      gl = g - (gh <<< 24);
      a = longint'(eta) * gh + (64'sd1 <<< 23) + ((longint'(eta) * gl) >>> 24);
      d = a >>> 24;
      r = longint'(w) - d;
      if (r > 64'sd2147483647) r = 64'sd2147483647;
      if (r < -64'sd2147483648) r = -64'sd2147483648;
      return int'(r);
   endfunction

   task automatic clear_weights();
      for (int i = 0; i < DEF_MAX_CLASSES*DEF_MAX_FEATURES; i++) weights[i] = 0;
   endtask

   task automatic apply_element(logic [1:0] op, logic [15:0] x, logic [3:0] label);
      svm_result_t e;
      int n, nc, best_c, misses;
      longint d, best, s;
      bit pos, miss;
      e = '{KIND_CLEAR, 4'd0, 48'sd0, 5'd0};
      if (op == OPC_CLEAR) begin
         clear_weights();
         element_num = 0;
         result_q = {result_q, e};
      end else if (op != OPC_IGNORE) begin
         n = used_features();
         nc = used_classes();
         sample_mem[element_num % DEF_MAX_FEATURES] = x;
         if (op == OPC_TRAIN) held_label = label;
         if (element_num + 1 < n) begin
            element_num++;
         end else begin
            element_num = 0;
            if (op == OPC_TRAIN) begin
               misses = 0;
               for (int c = 0; c < nc; c++) begin
                  d = class_score(c, n);
                  pos = (c == held_label);
                  miss = pos ? (d < (64'sd1 <<< 39)) : (d > -(64'sd1 <<< 39));
                  if (miss) misses++;
                  for (int j = 0; j < n; j++) begin
                     weights[c*DEF_MAX_FEATURES+j] =
                        stepped_weight(weights[c*DEF_MAX_FEATURES+j], sample_mem[j], miss, pos);
                  end
               end
               e.kind = KIND_TRAIN;
               e.misses = misses[4:0];
            end else begin
               best = class_score(0, n);
               best_c = 0;
               for (int c = 1; c < nc; c++) begin
                  d = class_score(c, n);
                  if (d > best) begin
                     best = d;
                     best_c = c;
                  end
               end
               s = best >>> 8;
               if (s > (64'sd1 <<< 47) - 1) s = (64'sd1 <<< 47) - 1;
               if (s < -(64'sd1 <<< 47)) s = -(64'sd1 <<< 47);
               e.kind = KIND_PREDICT;
               e.cls = best_c[3:0];
               e.score = s[47:0];
            end
            result_q = {result_q, e};
         end
      end
   endtask

   task automatic check_result();
      svm_result_t e;
      if (result_q.size() == 0) begin
         $error("Result transaction arrived with no result expected.");
         fail_count++;
      end else begin
         e = result_q.pop_front();
         if (rsp.result_kind !== e.kind) begin
            $error("result_kind expected %0d actual %0d", e.kind, rsp.result_kind);
            fail_count++;
         end
         if (rsp.predicted_class !== e.cls) begin
            $error("predicted_class expected %0d actual %0d", e.cls, rsp.predicted_class);
            fail_count++;
         end
         if (rsp.best_score !== e.score) begin
            $error("best_score expected %0d actual %0d", e.score, rsp.best_score);
            fail_count++;
         end
         if (rsp.margin_misses !== e.misses) begin
            $error("margin_misses expected %0d actual %0d", e.misses, rsp.margin_misses);
            fail_count++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         eta = RST_LEARN_RATE;
         lambda_q = RST_REG_LAMBDA;
         classes_reg = RST_CLASS_COUNT;
         features_reg = RST_FEATURE_COUNT;
         clear_weights();
         element_num = 0;
         held_label = 4'd0;
         result_q.delete();
         fail_count = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[3:2])
               CSR_LEARN_RATE: eta = csr_pwdata;
               CSR_REG_LAMBDA: lambda_q = csr_pwdata[19:0];
               CSR_CLASS_COUNT: classes_reg = csr_pwdata[4:0];
               CSR_FEATURE_COUNT: features_reg = csr_pwdata[12:0];
               default: ;
            endcase
         end
         if (rsp.valid && rsp.ready) check_result();
         if (req.valid && req.ready) begin
            apply_element(req.opcode, req.feature_value, req.sample_label);
         end
      end
      pending <= result_q.size();
   end

endmodule

// ----- test/tb_linear_svm_sgd_trainer.sv -----
// Testbench top for the SVM trainer: clock, reset, stimulus, stalls and the verdict.
`timescale 1ns / 1ps
module tb_linear_svm_sgd_trainer;
   import svmt_pkg::*;

   localparam int WATCHDOG_LIMIT = 400000;

   logic                  clock;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [31:0]           csr_pwdata;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;
   logic                  rsp_ready_r = 1'b0;
   int                    fail_count;
   int                    pending;
   int                    items_sent;
   int                    clears_sent;
   int                    idle_cycles;
   int                    ready_left;

   svmt_req_if req_if ();
   svmt_rsp_if rsp_if ();

   assign rsp_if.ready = rsp_ready_r;

   linear_svm_sgd_trainer u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_if),
      .rsp_ch      (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   svmt_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req         (req_if),
      .rsp         (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_pready  (csr_pready),
      .fail_count  (fail_count),
      .pending     (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready_r <= 1'b0;
         ready_left <= 0;
      end else if (ready_left == 0) begin
         if ($urandom_range(0, 3) != 0) begin
            rsp_ready_r <= 1'b1;
            ready_left <= ($urandom_range(0, 15) == 0) ? $urandom_range(100, 300)
                                                       : $urandom_range(1, 20);
         end else begin
            rsp_ready_r <= 1'b0;
            ready_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
                                                      : $urandom_range(1, 3);
         end
      end else begin
         ready_left <= ready_left - 1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)
          || (csr_psel && csr_penable)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
         end
      end
   end

   task automatic send(logic [1:0] op, logic [15:0] x, logic [3:0] label);
      int r;
      req_if.valid <= 1'b1;
      req_if.opcode <= op;
      req_if.feature_value <= x;
      req_if.sample_label <= label;
      do @(posedge clock); while (!req_if.ready);
      if (op != OPC_IGNORE) items_sent++;
      if (op == OPC_CLEAR) clears_sent++;
      r = $urandom_range(0, 9);
      if (r >= 6) begin
         req_if.valid <= 1'b0;
         repeat ((r == 9) ? $urandom_range(10, 40) : $urandom_range(1, 3)) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic csr_write(logic [1:0] index, logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {index, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic configure(logic [31:0] lr, logic [19:0] lam, logic [4:0] cc,
                            logic [12:0] fc);
      drain();
      csr_write(CSR_LEARN_RATE, lr);
      csr_write(CSR_REG_LAMBDA, {12'd0, lam});
      csr_write(CSR_CLASS_COUNT, {27'd0, cc});
      csr_write(CSR_FEATURE_COUNT, {19'd0, fc});
   endtask

   function automatic logic [15:0] rand_feature();
      return ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 32768));
   endfunction

   task automatic random_sequence(int fc, int cc);
      int r, len;
      logic [1:0] op;
      logic [3:0] label;
      r = $urandom_range(0, 99);
      label = ($urandom_range(0, 4) == 0) ? 4'($urandom) : 4'($urandom_range(0, cc - 1));
      if (r < 2 && clears_sent < 5) begin
         send(OPC_CLEAR, 16'($urandom), 4'($urandom));
      end else if (r < 8) begin
         send(OPC_IGNORE, 16'($urandom), 4'($urandom));
      end else if (r < 15) begin
         len = $urandom_range(1, fc);
         for (int i = 0; i < len; i++) begin
            send(2'($urandom_range(1, 3)), rand_feature(), 4'($urandom));
         end
      end else begin
         op = ($urandom_range(0, 9) < 7) ? OPC_TRAIN : OPC_PREDICT;
         for (int i = 0; i < fc; i++) begin
            if ($urandom_range(0, 9) == 0) op = 2'($urandom_range(1, 2));
            send(op, rand_feature(), label);
         end
      end
   endtask

   initial begin
      int fc, cc, samples, phase;
      logic [31:0] lr;
      logic [19:0] lam;
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.opcode = OPC_IGNORE;
      req_if.feature_value = 16'd0;
      req_if.sample_label = 4'd0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = 32'd0;
      items_sent = 0;
      clears_sent = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      configure(32'h4000_0000, 20'd1000, 5'd3, 13'd3);
      send(OPC_TRAIN, 16'd32768, 4'd0);
      send(OPC_TRAIN, 16'd32768, 4'd0);
      send(OPC_TRAIN, 16'd32768, 4'd0);
      send(OPC_TRAIN, 16'd0, 4'd2);
      send(OPC_TRAIN, 16'd16384, 4'd2);
      send(OPC_TRAIN, 16'd32768, 4'd2);
      send(OPC_TRAIN, 16'hFFFF, 4'd15);
      send(OPC_IGNORE, 16'hFFFF, 4'd15);
      send(OPC_TRAIN, 16'd1, 4'd15);
      send(OPC_TRAIN, 16'h7FFF, 4'd15);
      send(OPC_PREDICT, 16'd32768, 4'd0);
      send(OPC_PREDICT, 16'd0, 4'd0);
      send(OPC_PREDICT, 16'd32768, 4'd0);
      send(OPC_TRAIN, 16'd20000, 4'd1);
      send(OPC_PREDICT, 16'd20000, 4'd0);
      send(OPC_TRAIN, 16'd20000, 4'd1);
      send(OPC_TRAIN, 16'd9000, 4'd1);
      send(OPC_TRAIN, 16'd9000, 4'd1);
      send(OPC_PREDICT, 16'd9000, 4'd0);
      send(OPC_TRAIN, 16'd5, 4'd2);
      send(OPC_CLEAR, 16'd0, 4'd0);
      send(OPC_TRAIN, 16'd30000, 4'd1);
      send(OPC_TRAIN, 16'd30000, 4'd1);
      configure(32'h4000_0000, 20'd1000, 5'd3, 13'd1);
      send(OPC_PREDICT, 16'd12345, 4'd0);

      phase = 0;
      while (items_sent < 900) begin
         case (phase)
            0: begin lr = 32'd0; lam = 20'd0; cc = 0; fc = 0; end
            1: begin lr = 32'hFFFF_FFFF; lam = 20'hFFFFF; cc = 16; fc = 2; end
            2: begin lr = 32'hFFFF_FFFF; lam = 20'd0; cc = 31; fc = 3; end
            3: begin lr = 32'h8000_0000; lam = 20'd50; cc = 1; fc = 150; end
            default: begin
               lr = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(1 << 26, 1 << 31);
               lam = ($urandom_range(0, 3) == 0) ? 20'($urandom) : 20'($urandom_range(0, 4000));
               cc = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 16);
               fc = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
            end
         endcase
         configure(lr, lam, 5'(cc), 13'(fc));
         if (cc < 1) cc = 1;
         if (cc > 16) cc = 16;
         if (fc < 1) fc = 1;
         if (fc > DEF_MAX_FEATURES) fc = DEF_MAX_FEATURES;
         if (phase == 3) begin
            for (int i = 0; i < fc; i++) send(OPC_TRAIN, rand_feature(), 4'd0);
         end else begin
            samples = $urandom_range(3, 12);
            for (int s = 0; s < samples; s++) random_sequence(fc, cc);
         end
         phase++;
      end

      drain();
      repeat (200) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
